[sv/laa_pkg.sv]
// Package for the latching alarm annunciator: payload types, codes and the relay span function.
`default_nettype none
package laa_pkg;

  localparam int MODULES_DEF           = 4;
  localparam int RELAYS_PER_MODULE_DEF = 8;
  localparam int MASK_W                = 32;
  localparam int CFG_IDX_W             = 2;
  localparam int CFG_DATA_W            = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ALARM_POLARITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_ON_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINKED_RELAY_MASK = 2'd3;

  localparam logic        ALARM_POLARITY_RST    = 1'b1;
  localparam logic [7:0]  RELAY_ON_DELAY_RST    = 8'd0;
  localparam logic [15:0] TICKS_PER_SECOND_RST  = 16'd1000;
  localparam logic [31:0] LINKED_RELAY_MASK_RST = 32'd0;
  localparam logic [15:0] TICK_COUNT_MAX        = 16'hFFFF;

  localparam logic [1:0] CLS_INVALID  = 2'd0;
  localparam logic [1:0] CLS_ACTIVE   = 2'd1;
  localparam logic [1:0] CLS_INACTIVE = 2'd2;

  localparam logic [2:0] CODE_START   = 3'd0;
  localparam logic [2:0] CODE_WAIT    = 3'd1;
  localparam logic [2:0] CODE_DELAY   = 3'd2;
  localparam logic [2:0] CODE_UNACK   = 3'd3;
  localparam logic [2:0] CODE_ACKED   = 3'd4;
  localparam logic [2:0] CODE_RESET   = 3'd5;
  localparam logic [2:0] CODE_ACKWAIT = 3'd6;
  localparam logic [2:0] CODE_UNUSED  = 3'd7;

  typedef enum logic [6:0] {
    ST_START   = 7'b0000001,
    ST_WAIT    = 7'b0000010,
    ST_DELAY   = 7'b0000100,
    ST_UNACK   = 7'b0001000,
    ST_ACKED   = 7'b0010000,
    ST_RESET   = 7'b0100000,
    ST_ACKWAIT = 7'b1000000
  } state_t;

  typedef struct packed {
    logic input_level;
    logic input_invalid;
    logic time_tick;
    logic acknowledge;
    logic reset_alarm;
  } in_t;

  typedef struct packed {
    logic [2:0]        alarm_state;
    logic [1:0]        signal_class;
    logic              flags_written;
    logic              fresh_violation;
    logic              relay_request;
    logic [MASK_W-1:0] relay_write_mask;
  } out_t;

  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] c;
    case (s)
      ST_START:   c = CODE_START;
      ST_WAIT:    c = CODE_WAIT;
      ST_DELAY:   c = CODE_DELAY;
      ST_UNACK:   c = CODE_UNACK;
      ST_ACKED:   c = CODE_ACKED;
      ST_RESET:   c = CODE_RESET;
      ST_ACKWAIT: c = CODE_ACKWAIT;
      default:    c = CODE_UNUSED;
    endcase
    return c;
  endfunction

  // bit module*8+relay for every relay that exists, up to 4 modules of 8 relays
  function automatic logic [MASK_W-1:0] relay_span(input int modules, input int rpm);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 8; k++) begin
        if (j < modules && k < rpm) begin
          m[j*8+k] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[sv/latching_alarm_annunciator_core.sv]
// Latching alarm annunciator core: classifier, alarm sequencer and registered result.
// A result is registered and valid in the cycle after its input transaction is accepted.
// One transaction per cycle while out_ready is high; output drains as the next is taken.
// The sequencer state, delay counters and output register update in the accept cycle.
// Reset (rst, synchronous): start state, counters zero, registers at reset values, no result.
`default_nettype none
module latching_alarm_annunciator_core #(
  parameter int MODULES           = laa_pkg::MODULES_DEF,
  parameter int RELAYS_PER_MODULE = laa_pkg::RELAYS_PER_MODULE_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  laa_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output laa_pkg::out_t                      out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [laa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [laa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [laa_pkg::MASK_W-1:0] SPAN =
    laa_pkg::relay_span(MODULES, RELAYS_PER_MODULE);

  logic                        alarm_polarity;
  logic [7:0]                  relay_on_delay;
  logic [15:0]                 ticks_per_second;
  logic [laa_pkg::MASK_W-1:0]  linked_relay_mask;

  laa_pkg::state_t state, state_next;
  logic [7:0]      seconds_counted, seconds_counted_next;
  logic [15:0]     tick_count, tick_count_next;

  logic [1:0]  cls;
  logic        act, inact;
  logic        wrote, flag_val;
  logic [15:0] tick_inc;
  logic        accept;
  laa_pkg::out_t result;

  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (in_data.input_invalid) begin
      cls = laa_pkg::CLS_INVALID;
    end else if (in_data.input_level == alarm_polarity) begin
      cls = laa_pkg::CLS_ACTIVE;
    end else begin
      cls = laa_pkg::CLS_INACTIVE;
    end
    act   = (cls == laa_pkg::CLS_ACTIVE);
    inact = (cls == laa_pkg::CLS_INACTIVE);
    tick_inc = tick_count +
      16'(in_data.time_tick && (tick_count != laa_pkg::TICK_COUNT_MAX));

    state_next           = state;
    seconds_counted_next = seconds_counted;
    tick_count_next      = tick_count;
    wrote                = 1'b0;
    flag_val             = 1'b0;

    case (state)
      laa_pkg::ST_START: begin
        wrote      = 1'b1;
        state_next = laa_pkg::ST_WAIT;
      end
      laa_pkg::ST_WAIT: begin
        if (act) begin
          wrote    = 1'b1;
          flag_val = 1'b1;
          if (relay_on_delay != 8'd0) begin
            seconds_counted_next = '0;
            tick_count_next      = '0;
            state_next           = laa_pkg::ST_DELAY;
          end else begin
            state_next = laa_pkg::ST_UNACK;
          end
        end
      end
      laa_pkg::ST_DELAY: begin
        tick_count_next = tick_inc;
        if (act) begin
          if (tick_inc >= ticks_per_second) begin
            if (seconds_counted < relay_on_delay) begin
              seconds_counted_next = seconds_counted + 8'd1;
              tick_count_next      = '0;
            end else begin
              wrote      = 1'b1;
              flag_val   = 1'b1;
              state_next = laa_pkg::ST_UNACK;
            end
          end
        end else begin
          wrote      = 1'b1;
          state_next = laa_pkg::ST_WAIT;
        end
      end
      laa_pkg::ST_UNACK: begin
        if (act) begin
          wrote    = 1'b1;
          flag_val = 1'b1;
        end
        if (in_data.reset_alarm) begin
          state_next = laa_pkg::ST_RESET;
        end else if (in_data.acknowledge) begin
          state_next = laa_pkg::ST_ACKED;
        end
      end
      laa_pkg::ST_ACKED: begin
        if (in_data.reset_alarm) begin
          state_next = laa_pkg::ST_RESET;
        end else if (inact) begin
          state_next = laa_pkg::ST_ACKWAIT;
        end else if (act) begin
          wrote    = 1'b1;
          flag_val = 1'b1;
        end
      end
      laa_pkg::ST_RESET: begin
        if (inact) begin
          wrote      = 1'b1;
          state_next = laa_pkg::ST_WAIT;
        end else if (act) begin
          wrote    = 1'b1;
          flag_val = 1'b1;
        end
      end
      laa_pkg::ST_ACKWAIT: begin
        if (act) begin
          wrote    = 1'b1;
          flag_val = 1'b1;
        end
        if (in_data.reset_alarm) begin
          wrote      = 1'b1;
          flag_val   = 1'b0;
          state_next = laa_pkg::ST_WAIT;
        end
      end
      default: begin
        state_next = state;
      end
    endcase

    result.alarm_state      = laa_pkg::state_code(state_next);
    result.signal_class     = cls;
    result.flags_written    = wrote;
    result.fresh_violation  = flag_val;
    result.relay_request    = flag_val;
    result.relay_write_mask = wrote ? (linked_relay_mask & SPAN) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_polarity    <= laa_pkg::ALARM_POLARITY_RST;
      relay_on_delay    <= laa_pkg::RELAY_ON_DELAY_RST;
      ticks_per_second  <= laa_pkg::TICKS_PER_SECOND_RST;
      linked_relay_mask <= laa_pkg::LINKED_RELAY_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        laa_pkg::REG_ALARM_POLARITY:    alarm_polarity    <= cfg_data[0];
        laa_pkg::REG_RELAY_ON_DELAY:    relay_on_delay    <= cfg_data[7:0];
        laa_pkg::REG_TICKS_PER_SECOND:  ticks_per_second  <= cfg_data[15:0];
        laa_pkg::REG_LINKED_RELAY_MASK: linked_relay_mask <= cfg_data[laa_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= laa_pkg::ST_START;
      seconds_counted <= '0;
      tick_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        state           <= state_next;
        seconds_counted <= seconds_counted_next;
        tick_count      <= tick_count_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_no_write_zero_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.flags_written) |->
      (!out_data.fresh_violation && !out_data.relay_request &&
       out_data.relay_write_mask == '0))
    else $error("flags reported without a write");

  a_flags_agree: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.fresh_violation == out_data.relay_request))
    else $error("new violation and relay request disagree");

  a_start_goes_wait: assert property (@(posedge clk) disable iff (rst)
    (accept && state == laa_pkg::ST_START) |=>
      (out_valid && out_data.alarm_state == laa_pkg::CODE_WAIT &&
       out_data.flags_written && !out_data.fresh_violation))
    else $error("start state did not write normal and move to waiting");

endmodule
`default_nettype wire
